[rtl/csrv_pkg.sv]
// shared types, constants and helper functions of the value-indexed csr spmv core
package csrv_pkg;

    localparam int VALUE_TABLE_DEPTH_DEF = 256;
    localparam int X_DEPTH_DEF           = 4096;
    localparam int QUEUE_DEPTH           = 4;

    localparam int ADDR_W = 8;
    localparam int COL_W  = 12;
    localparam int DATA_W = 64;
    localparam int ROW_W  = 32;

    localparam logic [DATA_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [DATA_W-1:0] INF_BITS  = 64'h7FF0_0000_0000_0000;

    typedef enum logic [1:0] {
        CMD_LOAD_TABLE = 2'd0,
        CMD_LOAD_X     = 2'd1,
        CMD_NONZERO    = 2'd2,
        CMD_EMPTY_ROW  = 2'd3
    } csrv_cmd_t;

    typedef struct packed {
        logic              fma;
        logic              emit;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } csrv_op_t;

    typedef struct packed {
        logic [127:0] v;
        logic [6:0]   n;
    } csrv_norm_t;

    // shift left by whole 16-bit groups until the top group is nonzero
    function automatic csrv_norm_t csrv_norm_coarse(input logic [127:0] v);
        csrv_norm_t r;
        logic [2:0] idx;
        logic       found;
        idx   = '0;
        found = 1'b0;
        for (int g = 0; g < 8; g++)
        begin
            if (!found && (v[127-16*g -: 16] != '0))
            begin
                idx   = 3'(g);
                found = 1'b1;
            end
        end
        r.n = {idx, 4'b0000};
        r.v = v << r.n;
        return r;
    endfunction

    // finish the shift inside the top group
    function automatic csrv_norm_t csrv_norm_fine(input logic [127:0] v);
        csrv_norm_t r;
        logic [3:0] idx;
        logic       found;
        idx   = '0;
        found = 1'b0;
        for (int g = 0; g < 16; g++)
        begin
            if (!found && v[127-g])
            begin
                idx   = 4'(g);
                found = 1'b1;
            end
        end
        r.n = {3'b000, idx};
        r.v = v << idx;
        return r;
    endfunction

    // right shift with the lost bits folded into bit 0, 128 or more leaves only that sticky bit
    function automatic logic [127:0] csrv_shr_jam(input logic [127:0] v, input logic [7:0] d);
        logic [127:0] r;
        logic [127:0] mask;
        if (d[7])
        begin
            r = {127'b0, |v};
        end
        else
        begin
            mask = ~({128{1'b1}} << d[6:0]);
            r    = v >> d[6:0];
            r[0] = r[0] | (|(v & mask));
        end
        return r;
    endfunction

endpackage

[rtl/csrv_if.sv]
// item and result channel interfaces
interface csrv_item_if
    import csrv_pkg::*;
();
    logic              valid;
    logic              ready;
    csrv_cmd_t         cmd;
    logic [ADDR_W-1:0] table_addr;
    logic [COL_W-1:0]  column;
    logic [DATA_W-1:0] data;
    logic              row_end;

    modport source (output valid, cmd, table_addr, column, data, row_end, input ready);
    modport sink   (input valid, cmd, table_addr, column, data, row_end, output ready);
endinterface

interface csrv_result_if
    import csrv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_index;
    logic [DATA_W-1:0] row_sum;

    modport source (output valid, row_index, row_sum, input ready);
    modport sink   (input valid, row_index, row_sum, output ready);
endinterface

[rtl/csr_value_indexed_spmv_core.sv]
// top level of the value-indexed csr sparse matrix-vector multiply core
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  item     | in  | valid / ready | cmd, table_addr, column, data, row_end
//  result   | out | valid / ready | row_index, row_sum
//
// loads write the table or x in the front and empty rows pass its s1 register; a nonzero
// holds the accumulator loop through issue and the 12-stage fma, and a row close adds the
// emit state; the fma latency on the accumulator dependency sets the nonzero rate
// reset clears queue, accumulator, row counter and result register; table and x
// are undefined until loaded, with no clearing pass
// a stalled result stalls the back end only; the front keeps taking transfers
// until the four-entry queue and its own s1 register are full
module csr_value_indexed_spmv_core
    import csrv_pkg::*;
#(
    parameter int VALUE_TABLE_DEPTH = VALUE_TABLE_DEPTH_DEF,
    parameter int X_DEPTH           = X_DEPTH_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    csrv_item_if.sink     item,
    csrv_result_if.source result
);
    logic     push, full, pop, empty;
    csrv_op_t push_op, head;

    csrv_front #(
        .VALUE_TABLE_DEPTH (VALUE_TABLE_DEPTH),
        .X_DEPTH           (X_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .push    (push),
        .push_op (push_op),
        .full    (full)
    );

    csrv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .head    (head),
        .empty   (empty)
    );

    csrv_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );
endmodule

[rtl/csrv_fifo.sv]
// short operation queue between front and back
module csrv_fifo
    import csrv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  csrv_op_t push_op,
    output logic     full,
    input  logic     pop,
    output csrv_op_t head,
    output logic     empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    csrv_op_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
        else $error("queue written while full");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
endmodule

[rtl/csrv_fma.sv]
// twelve-stage binary64 fused multiply-add, round to nearest even
module csrv_fma
    import csrv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic [DATA_W-1:0] c,
    output logic              done,
    output logic [DATA_W-1:0] res
);
    localparam int NSTG = 12;

    typedef logic signed [13:0] exp_t;

    typedef struct packed {
        logic              spc;
        logic [DATA_W-1:0] spv;
    } tag_t;

    typedef struct packed {
        exp_t xp;
        exp_t xc;
        logic sp;
        logic sc;
        logic cz;
    } pre_t;

    logic [NSTG-1:0] vld_reg;
    tag_t            tag_reg [NSTG];
    pre_t            pre_reg [4];
    // sign and exponent from stage 5 to 10, zero flag from stage 8 to 10
    logic            sgn_reg [6];
    exp_t            xs_reg  [6];
    logic            rz_reg  [3];

    // unpack and special cases
    logic [10:0] ea, eb, ec, ea1, eb1, ec1;
    logic [51:0] fa, fb, fc;
    logic        sp, sc, az, bz, cz, spc;
    logic [DATA_W-1:0] spv;
    pre_t        pre0;

    assign ea  = a[62:52];
    assign eb  = b[62:52];
    assign ec  = c[62:52];
    assign fa  = a[51:0];
    assign fb  = b[51:0];
    assign fc  = c[51:0];
    assign sp  = a[63] ^ b[63];
    assign sc  = c[63];
    assign az  = (ea == '0) && (fa == '0);
    assign bz  = (eb == '0) && (fb == '0);
    assign cz  = (ec == '0) && (fc == '0);
    assign ea1 = (ea != '0) ? ea : 11'd1;
    assign eb1 = (eb != '0) ? eb : 11'd1;
    assign ec1 = (ec != '0) ? ec : 11'd1;

    always_comb
    begin
        spc = 1'b1;
        spv = '0;
        if ((ea == '1 && fa != '0) || (eb == '1 && fb != '0) || (ec == '1 && fc != '0))
        begin
            spv = QNAN_BITS;
        end
        else if (ea == '1 || eb == '1)
        begin
            if (az || bz)
            begin
                spv = QNAN_BITS;
            end
            else if (ec == '1 && sc != sp)
            begin
                spv = QNAN_BITS;
            end
            else
            begin
                spv = {sp, 63'b0} | INF_BITS;
            end
        end
        else if (ec == '1)
        begin
            spv = c;
        end
        else if (az || bz)
        begin
            spv = cz ? {sp & sc, 63'b0} : c;
        end
        else
        begin
            spc = 1'b0;
        end
        pre0.xp = $signed(14'(ea1)) + $signed(14'(eb1)) - 14'sd2150;
        pre0.xc = $signed(14'(ec1)) - 14'sd1075;
        pre0.sp = sp;
        pre0.sc = sc;
        pre0.cz = cz;
    end

    logic [52:0]  ma_reg, mb_reg, mc0_reg, mc1_reg, mc2_reg;
    logic [53:0]  pp0_reg;
    logic [52:0]  pp1_reg, pp2_reg;
    logic [51:0]  pp3_reg;
    logic [105:0] p2_reg;
    csrv_norm_t   pa3_reg, qa3_reg;
    logic [127:0] p4_reg, q4_reg;
    exp_t         xp4_reg, xc4_reg;
    logic         sp4_reg, sc4_reg, cz4_reg;
    logic [127:0] big5_reg, small5_reg, big6_reg, small6_reg, r7_reg, rn9_reg, rs10_reg;
    logic         sub5_reg, sub6_reg;
    logic [7:0]   d5_reg, e9_reg;
    csrv_norm_t   ra8_reg;
    exp_t         s9_reg, s10_reg;
    logic [DATA_W-1:0] res_reg;

    // stage 4: fine normalise of product and addend
    csrv_norm_t pf, qf;
    logic [6:0] lp, lq;
    assign pf = csrv_norm_fine(pa3_reg.v);
    assign qf = csrv_norm_fine(qa3_reg.v);
    assign lp = pa3_reg.n + pf.n;
    assign lq = qa3_reg.n + qf.n;

    // stage 5: order by magnitude
    logic p_big;
    exp_t dd;
    assign p_big = (xp4_reg > xc4_reg) || ((xp4_reg == xc4_reg) && (p4_reg >= q4_reg));
    assign dd    = p_big ? (xp4_reg - xc4_reg) : (xc4_reg - xp4_reg);

    // stage 9: rounding position with gradual underflow
    csrv_norm_t rf;
    logic [6:0] lr;
    exp_t       s0, cl, ex;
    assign rf = csrv_norm_fine(ra8_reg.v);
    assign lr = ra8_reg.n + rf.n;
    assign s0 = 14'sd75 - $signed({7'b0, lr});
    assign cl = -14'sd1074 - xs_reg[3];
    assign ex = cl - s0;

    // stage 11: round and pack
    logic [52:0] mt;
    logic        rb, st, inc;
    logic [53:0] m1;
    logic [52:0] mf;
    exp_t        be;
    logic [DATA_W-1:0] packed_val;
    assign mt  = rs10_reg[127:75];
    assign rb  = rs10_reg[74];
    assign st  = |rs10_reg[73:0];
    assign inc = rb & (st | mt[0]);
    assign m1  = {1'b0, mt} + 54'(inc);
    assign mf  = m1[53] ? m1[53:1] : m1[52:0];
    assign be  = xs_reg[5] + s10_reg + 14'sd1075 + $signed({13'b0, m1[53]});

    always_comb
    begin
        if (tag_reg[10].spc)
        begin
            packed_val = tag_reg[10].spv;
        end
        else if (rz_reg[2])
        begin
            packed_val = '0;
        end
        else if (mf == '0)
        begin
            packed_val = {sgn_reg[5], 63'b0};
        end
        else if (!mf[52])
        begin
            packed_val = {sgn_reg[5], 11'b0, mf[51:0]};
        end
        else if (be >= 14'sd2047)
        begin
            packed_val = {sgn_reg[5], 63'b0} | INF_BITS;
        end
        else
        begin
            packed_val = {sgn_reg[5], be[10:0], mf[51:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= '{spc: spc, spv: spv};
        for (int i = 1; i < NSTG; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        for (int i = 1; i < 6; i++)
        begin
            sgn_reg[i] <= sgn_reg[i-1];
            xs_reg[i]  <= xs_reg[i-1];
        end
        for (int i = 1; i < 3; i++)
        begin
            rz_reg[i] <= rz_reg[i-1];
        end
        pre_reg[0] <= pre0;
        for (int i = 1; i < 4; i++)
        begin
            pre_reg[i] <= pre_reg[i-1];
        end
        // stage 0
        ma_reg  <= {ea != '0, fa};
        mb_reg  <= {eb != '0, fb};
        mc0_reg <= {ec != '0, fc};
        // stage 1: partial products
        pp0_reg <= ma_reg[26:0] * mb_reg[26:0];
        pp1_reg <= ma_reg[26:0] * mb_reg[52:27];
        pp2_reg <= ma_reg[52:27] * mb_reg[26:0];
        pp3_reg <= ma_reg[52:27] * mb_reg[52:27];
        mc1_reg <= mc0_reg;
        // stage 2: product sum
        p2_reg  <= 106'(pp0_reg) + (106'(pp1_reg) << 27) + (106'(pp2_reg) << 27)
                   + (106'(pp3_reg) << 54);
        mc2_reg <= mc1_reg;
        // stage 3: coarse normalise
        pa3_reg <= csrv_norm_coarse({22'b0, p2_reg});
        qa3_reg <= csrv_norm_coarse({75'b0, mc2_reg});
        // stage 4
        p4_reg  <= pf.v >> 3;
        q4_reg  <= qf.v >> 3;
        xp4_reg <= pre_reg[3].xp - $signed({7'b0, lp}) + 14'sd3;
        xc4_reg <= pre_reg[3].xc - $signed({7'b0, lq}) + 14'sd3;
        sp4_reg <= pre_reg[3].sp;
        sc4_reg <= pre_reg[3].sc;
        cz4_reg <= pre_reg[3].cz;
        // stage 5
        if (cz4_reg || p_big)
        begin
            big5_reg   <= p4_reg;
            small5_reg <= cz4_reg ? '0 : q4_reg;
            sgn_reg[0] <= sp4_reg;
            xs_reg[0]  <= xp4_reg;
            sub5_reg   <= !cz4_reg && (sp4_reg != sc4_reg);
        end
        else
        begin
            big5_reg   <= q4_reg;
            small5_reg <= p4_reg;
            sgn_reg[0] <= sc4_reg;
            xs_reg[0]  <= xc4_reg;
            sub5_reg   <= sp4_reg != sc4_reg;
        end
        d5_reg <= (cz4_reg || dd > 14'sd127) ? (cz4_reg ? 8'd0 : 8'd128) : 8'(dd);
        // stage 6: align
        big6_reg   <= big5_reg;
        small6_reg <= csrv_shr_jam(small5_reg, d5_reg);
        sub6_reg   <= sub5_reg;
        // stage 7: add or subtract
        r7_reg <= sub6_reg ? (big6_reg - small6_reg) : (big6_reg + small6_reg);
        // stage 8
        ra8_reg   <= csrv_norm_coarse(r7_reg);
        rz_reg[0] <= (r7_reg == '0);
        // stage 9
        rn9_reg <= rf.v;
        if (cl > s0)
        begin
            s9_reg <= cl;
            e9_reg <= (ex > 14'sd127) ? 8'd128 : 8'(ex);
        end
        else
        begin
            s9_reg <= s0;
            e9_reg <= 8'd0;
        end
        // stage 10
        rs10_reg <= csrv_shr_jam(rn9_reg, e9_reg);
        s10_reg  <= s9_reg;
        // stage 11
        res_reg <= packed_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], start};
        end
    end

    assign done = vld_reg[NSTG-1];
    assign res  = res_reg;
endmodule

[rtl/csrv_front.sv]
// front end: takes item transfers, keeps value table and x, queues row work
module csrv_front
    import csrv_pkg::*;
#(
    parameter int VALUE_TABLE_DEPTH = VALUE_TABLE_DEPTH_DEF,
    parameter int X_DEPTH           = X_DEPTH_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    csrv_item_if.sink     item,
    output logic          push,
    output csrv_op_t      push_op,
    input  logic          full
);
    localparam int TW = $clog2(VALUE_TABLE_DEPTH);
    localparam int XW = $clog2(X_DEPTH);

    logic [DATA_W-1:0] tbl_mem [VALUE_TABLE_DEPTH];
    logic [DATA_W-1:0] x_mem   [X_DEPTH];
    logic [DATA_W-1:0] tbl_rd_reg;
    logic [DATA_W-1:0] x_rd_reg;

    logic s1_valid_reg, s1_nz_reg, s1_emit_reg, s1_tok_reg, s1_xok_reg;
    logic accept, tbl_ok, col_ok, is_op;

    assign item.ready = !s1_valid_reg || !full;
    assign accept     = item.valid && item.ready;
    assign tbl_ok     = 32'(item.table_addr) < 32'(VALUE_TABLE_DEPTH);
    assign col_ok     = 32'(item.column) < 32'(X_DEPTH);
    assign is_op      = (item.cmd == CMD_NONZERO) || (item.cmd == CMD_EMPTY_ROW);

    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == CMD_LOAD_TABLE && tbl_ok)
        begin
            tbl_mem[TW'(item.table_addr)] <= item.data;
        end
        if (accept && item.cmd == CMD_LOAD_X && col_ok)
        begin
            x_mem[XW'(item.column)] <= item.data;
        end
        if (accept && item.cmd == CMD_NONZERO)
        begin
            tbl_rd_reg <= tbl_mem[TW'(item.table_addr)];
            x_rd_reg   <= x_mem[XW'(item.column)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_nz_reg    <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_tok_reg   <= 1'b0;
            s1_xok_reg   <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= is_op;
            s1_nz_reg    <= item.cmd == CMD_NONZERO;
            s1_emit_reg  <= (item.cmd == CMD_EMPTY_ROW) || item.row_end;
            s1_tok_reg   <= tbl_ok;
            s1_xok_reg   <= col_ok;
        end
        else if (push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    assign push         = s1_valid_reg && !full;
    assign push_op.fma  = s1_nz_reg;
    assign push_op.emit = s1_emit_reg;
    assign push_op.a    = s1_tok_reg ? tbl_rd_reg : '0;
    assign push_op.b    = s1_xok_reg ? x_rd_reg : '0;
endmodule

[rtl/csrv_back.sv]
// back end: accumulates row sums through the fma and holds the result register
module csrv_back
    import csrv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  csrv_op_t     head,
    input  logic         empty,
    output logic         pop,
    csrv_result_if.source result
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

    state_t            st_reg;
    logic              emit_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [ROW_W-1:0]  cnt_reg;
    logic              out_valid_reg;
    logic [ROW_W-1:0]  out_idx_reg;
    logic [DATA_W-1:0] out_sum_reg;
    logic              start, fma_done, take;
    logic [DATA_W-1:0] fma_res;

    assign pop   = (st_reg == ST_IDLE) && !empty;
    assign start = pop && head.fma;
    assign take  = !out_valid_reg || result.ready;

    csrv_fma u_fma (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .a     (head.a),
        .b     (head.b),
        .c     (acc_reg),
        .done  (fma_done),
        .res   (fma_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            emit_reg      <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_sum_reg   <= '0;
        end
        else
        begin
            if (st_reg == ST_EMIT && take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        emit_reg <= head.emit;
                        st_reg   <= head.fma ? ST_RUN : ST_EMIT;
                    end
                end
                ST_RUN:
                begin
                    if (fma_done)
                    begin
                        acc_reg <= fma_res;
                        st_reg  <= emit_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (take)
                    begin
                        out_idx_reg   <= cnt_reg;
                        out_sum_reg   <= acc_reg;
                        acc_reg       <= '0;
                        cnt_reg       <= cnt_reg + 1'b1;
                        st_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.row_index = out_idx_reg;
    assign result.row_sum   = out_sum_reg;

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        fma_done |-> st_reg == ST_RUN)
        else $error("fma result with no operation in flight");
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_EMIT && take) |=> acc_reg == '0 && out_valid_reg)
        else $error("row close did not load result and clear sum");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |-> $past(st_reg) == ST_EMIT)
        else $error("row counter moved outside a row close");
endmodule

[test/csr_value_indexed_spmv_core_test.sv]
// self-checking testbench of the value-indexed csr sparse matrix-vector multiply core
module csr_value_indexed_spmv_core_test;
    import csrv_pkg::*;

    typedef struct {
        csrv_cmd_t         cmd;
        logic [ADDR_W-1:0] table_addr;
        logic [COL_W-1:0]  column;
        logic [DATA_W-1:0] data;
        logic              row_end;
        bit                typed;
        logic [DATA_W-1:0] typed_sum;
    } stim_t;

    typedef struct {
        logic [ROW_W-1:0]  row_index;
        logic [DATA_W-1:0] row_sum;
    } row_result_t;

    localparam logic [DATA_W-1:0] POS_ZERO = 64'h0;
    localparam logic [DATA_W-1:0] ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [DATA_W-1:0] HALF     = 64'h3FE0_0000_0000_0000;
    localparam logic [DATA_W-1:0] TWO      = 64'h4000_0000_0000_0000;
    localparam logic [DATA_W-1:0] THREE    = 64'h4008_0000_0000_0000;
    localparam logic [DATA_W-1:0] MAX_NORM = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_SUB  = 64'h0000_0000_0000_0001;
    localparam logic [DATA_W-1:0] SIGN     = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] SNAN     = 64'h7FF4_0000_0000_0001;

    logic clk;
    logic rst_n;

    csrv_item_if   item_ch ();
    csrv_result_if result_ch ();

    csr_value_indexed_spmv_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    logic [DATA_W-1:0] value_mem [VALUE_TABLE_DEPTH_DEF];
    logic [DATA_W-1:0] x_mem [X_DEPTH_DEF];
    logic [DATA_W-1:0] row_acc;
    logic [ROW_W-1:0]  row_count;
    int                value_written [$];
    int                x_written [$];
    row_result_t       pending_rows [$];
    stim_t             directed [$];

    int  errors;
    int  mismatches;
    bit  quiet;
    bit  hold_req;
    int  hold_left;
    int  burst_left;
    bit  burst_ready;

    function automatic int top_bit(input logic [127:0] v);
        for (int i = 127; i > 0; i--)
        begin
            if (v[i])
                return i;
        end
        return 0;
    endfunction

    function automatic logic [127:0] shr_sticky(input logic [127:0] v, input int n);
        logic [127:0] r;
        if (n <= 0)
            return v;
        if (n >= 128)
            return {127'b0, |v};
        r    = v >> n;
        r[0] = r[0] | (|(v & ~({128{1'b1}} << n)));
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] round_to_double(input logic [DATA_W-1:0] sgn,
                                                           input logic [127:0] r, input int x);
        int           k;
        int           s;
        int           be;
        logic [127:0] t;
        logic [63:0]  m;
        k = top_bit(r);
        s = k - 52;
        if (-1074 - x > s)
            s = -1074 - x;
        t = (s >= 2) ? shr_sticky(r, s - 2) : (r << (2 - s));
        m = {2'b00, t[63:2]};
        if (t[1] && (t[0] || m[0]))
            m++;
        if (m >= 64'h0020_0000_0000_0000)
        begin
            m = m >> 1;
            s++;
        end
        if (m == 0)
            return sgn;
        if (m < 64'h0010_0000_0000_0000)
            return sgn | m;
        be = x + s + 52 + 1023;
        if (be >= 2047)
            return sgn | INF_BITS;
        return sgn | (64'(be) << 52) | (m & 64'h000F_FFFF_FFFF_FFFF);
    endfunction

    function automatic logic [DATA_W-1:0] fused_madd(input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b,
                                                     input logic [DATA_W-1:0] c);
        int           ea, eb, ec, kp, kc, xp, xc, xbig, xsmall;
        logic [51:0]  fa, fb, fc;
        logic [63:0]  sp, sc, sbig, ssmall;
        bit           az, bz, cz;
        logic [127:0] p, q, big, lesser, r;
        ea = a[62:52];
        eb = b[62:52];
        ec = c[62:52];
        fa = a[51:0];
        fb = b[51:0];
        fc = c[51:0];
        sp = (a ^ b) & SIGN;
        sc = c & SIGN;
        az = (ea == 0 && fa == 0);
        bz = (eb == 0 && fb == 0);
        cz = (ec == 0 && fc == 0);
        if ((ea == 2047 && fa != 0) || (eb == 2047 && fb != 0) || (ec == 2047 && fc != 0))
            return QNAN_BITS;
        if (ea == 2047 || eb == 2047)
        begin
            if (az || bz)
                return QNAN_BITS;
            if (ec == 2047 && sc != sp)
                return QNAN_BITS;
            return sp | INF_BITS;
        end
        if (ec == 2047)
            return c;
        if (az || bz)
        begin
            if (cz)
                return sp & sc;
            return c;
        end
        p  = {75'b0, (ea != 0), fa} * {75'b0, (eb != 0), fb};
        kp = top_bit(p);
        p  = p << (124 - kp);
        xp = (ea != 0 ? ea : 1) - 1075 + (eb != 0 ? eb : 1) - 1075 - (124 - kp);
        if (cz)
            return round_to_double(sp, p, xp);
        q  = {75'b0, (ec != 0), fc};
        kc = top_bit(q);
        q  = q << (124 - kc);
        xc = (ec != 0 ? ec : 1) - 1075 - (124 - kc);
        if (xp > xc || (xp == xc && p >= q))
        begin
            big = p; xbig = xp; sbig = sp; lesser = q; xsmall = xc; ssmall = sc;
        end
        else
        begin
            big = q; xbig = xc; sbig = sc; lesser = p; xsmall = xp; ssmall = sp;
        end
        lesser = shr_sticky(lesser, xbig - xsmall);
        r = (sbig == ssmall) ? big + lesser : big - lesser;
        if (r == 0)
            return POS_ZERO;
        return round_to_double(sbig, r, xbig);
    endfunction

    // advance the row state by one accepted transfer, queue the row it closes
    function automatic void spmv_update(input stim_t s);
        row_result_t res;
        bit          closes;
        closes = 1'b0;
        case (s.cmd)
            CMD_LOAD_TABLE: value_mem[s.table_addr] = s.data;
            CMD_LOAD_X:     x_mem[s.column] = s.data;
            CMD_NONZERO:
            begin
                row_acc = fused_madd(value_mem[s.table_addr], x_mem[s.column], row_acc);
                closes  = s.row_end;
            end
            default:        closes = 1'b1;
        endcase
        if (closes)
        begin
            res.row_index = row_count;
            res.row_sum   = s.typed ? s.typed_sum : row_acc;
            pending_rows.push_back(res);
            row_count++;
            row_acc = POS_ZERO;
        end
    endfunction

    function automatic void add_row(input csrv_cmd_t cmd, input int addr, input int col,
                                    input logic [DATA_W-1:0] data, input logic re,
                                    input int typed, input logic [DATA_W-1:0] sum);
        stim_t s;
        s.cmd        = cmd;
        s.table_addr = ADDR_W'(addr);
        s.column     = COL_W'(col);
        s.data       = data;
        s.row_end    = re;
        s.typed      = (typed != 0);
        s.typed_sum  = sum;
        directed.push_back(s);
    endfunction

    function automatic logic [DATA_W-1:0] random_double();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return {1'($urandom), 11'($urandom_range(1013, 1033)), 20'($urandom), 32'($urandom)};
        if (pick < 86)
            return {$urandom, $urandom};
        if (pick < 90)
            return {1'($urandom), 11'd0, 20'($urandom), 32'($urandom)};
        case ($urandom_range(0, 4))
            0:       return POS_ZERO | (SIGN & {$urandom, 32'b0});
            1:       return INF_BITS | (SIGN & {$urandom, 32'b0});
            2:       return QNAN_BITS;
            3:       return MAX_NORM | (SIGN & {$urandom, 32'b0});
            default: return {1'($urandom), 11'($urandom_range(1800, 2046)), 52'($urandom)};
        endcase
    endfunction

    function automatic stim_t random_stim();
        stim_t s;
        int    pick;
        s.typed      = 1'b0;
        s.typed_sum  = POS_ZERO;
        s.table_addr = ADDR_W'($urandom);
        s.column     = COL_W'($urandom);
        s.data       = random_double();
        s.row_end    = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (value_written.size() == 0 || x_written.size() == 0 || pick < 12)
            s.cmd = (value_written.size() == 0 || (x_written.size() != 0 && pick % 2 == 0))
                    ? CMD_LOAD_TABLE : CMD_LOAD_X;
        else if (pick < 20)
            s.cmd = CMD_LOAD_X;
        else if (pick < 26)
            s.cmd = CMD_EMPTY_ROW;
        else
        begin
            s.cmd        = CMD_NONZERO;
            s.table_addr = ADDR_W'(value_written[$urandom_range(0, value_written.size() - 1)]);
            s.column     = COL_W'(x_written[$urandom_range(0, x_written.size() - 1)]);
            s.row_end    = ($urandom_range(0, 3) == 0);
        end
        if (s.cmd == CMD_LOAD_TABLE)
            value_written.push_back(int'(s.table_addr));
        if (s.cmd == CMD_LOAD_X)
            x_written.push_back(int'(s.column));
        return s;
    endfunction

    task automatic send(input stim_t s);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= s.cmd;
        item_ch.table_addr <= s.table_addr;
        item_ch.column     <= s.column;
        item_ch.data       <= s.data;
        item_ch.row_end    <= s.row_end;
        do
            @(posedge clk);
        while (!item_ch.ready);
        spmv_update(s);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side readiness: random bursts, one long hold-off, steady at the end
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (quiet)
                result_ch.ready <= 1'b1;
            else if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_ready = ($urandom_range(0, 2) != 0);
                    burst_left  = burst_ready ? $urandom_range(1, 40) : $urandom_range(1, 8);
                end
                burst_left--;
                result_ch.ready <= burst_ready;
            end
        end
    end

    always @(posedge clk)
    begin
        row_result_t exp_row;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_rows.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected row %0d sum %h", result_ch.row_index, result_ch.row_sum);
                mismatches++;
            end
            else
            begin
                exp_row = pending_rows.pop_front();
                if (exp_row.row_index !== result_ch.row_index
                    || exp_row.row_sum !== result_ch.row_sum)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("row mismatch: expected %0d %h, got %0d %h",
                                 exp_row.row_index, exp_row.row_sum,
                                 result_ch.row_index, result_ch.row_sum);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        stim_t s;
        errors     = 0;
        mismatches = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        hold_left  = 0;
        burst_left = 0;
        row_acc    = POS_ZERO;
        row_count  = '0;
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.cmd        = CMD_LOAD_TABLE;
        item_ch.table_addr = '0;
        item_ch.column     = '0;
        item_ch.data       = '0;
        item_ch.row_end    = 1'b0;
        result_ch.ready    = 1'b0;

        // empty row straight after reset, then the corners
        add_row(CMD_EMPTY_ROW,  0,    0,    POS_ZERO, 1'b0, 1, POS_ZERO);
        add_row(CMD_LOAD_TABLE, 0,    0,    ONE,        1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_TABLE, 255,  0,    TWO | SIGN, 1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_TABLE, 1,    0,    POS_ZERO,   1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_TABLE, 2,    0,    SNAN,       1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_X,     0,    0,    THREE,      1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_X,     0,    4095, INF_BITS,   1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_X,     0,    1,    HALF,       1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_X,     0,    2,    THREE | SIGN, 1'b1, 0, POS_ZERO);
        add_row(CMD_NONZERO,    0,    0,    '1,         1'b0, 0, POS_ZERO);
        add_row(CMD_NONZERO,    255,  0,    '0,         1'b1, 1, THREE | SIGN);
        add_row(CMD_NONZERO,    0,    4095, '0,         1'b1, 1, INF_BITS);
        add_row(CMD_NONZERO,    1,    4095, '0,         1'b1, 1, QNAN_BITS);
        add_row(CMD_NONZERO,    2,    0,    '0,         1'b1, 1, QNAN_BITS);
        add_row(CMD_NONZERO,    0,    0,    '0,         1'b0, 0, POS_ZERO);
        add_row(CMD_NONZERO,    0,    2,    '0,         1'b1, 1, POS_ZERO);
        add_row(CMD_NONZERO,    0,    0,    '0,         1'b0, 0, POS_ZERO);
        add_row(CMD_EMPTY_ROW,  255,  4095, '1,         1'b1, 1, THREE);
        add_row(CMD_LOAD_TABLE, 3,    0,    MIN_SUB,    1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_X,     0,    3,    HALF,       1'b0, 0, POS_ZERO);
        add_row(CMD_NONZERO,    3,    3,    '0,         1'b1, 0, POS_ZERO);
        add_row(CMD_LOAD_TABLE, 4,    0,    MAX_NORM,   1'b0, 0, POS_ZERO);
        add_row(CMD_LOAD_X,     0,    4,    TWO,        1'b0, 0, POS_ZERO);
        add_row(CMD_NONZERO,    4,    4,    '0,         1'b1, 0, POS_ZERO);
        add_row(CMD_NONZERO,    3,    1,    '0,         1'b1, 0, POS_ZERO);
        foreach (directed[i])
        begin
            if (directed[i].cmd == CMD_LOAD_TABLE)
                value_written.push_back(int'(directed[i].table_addr));
            if (directed[i].cmd == CMD_LOAD_X)
                x_written.push_back(int'(directed[i].column));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i]);

        for (int n = 0; n < 1625; n++)
        begin
            if (n == 600)
                hold_req = 1'b1;
            if (n == 1450)
                quiet = 1'b1;
            s = random_stim();
            send(s);
        end
        item_ch.valid <= 1'b0;

        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
